/* hw/rtl/ffd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

    // frame marks and command codes
    localparam logic [7:0] HEADER_MARK  = 8'hFE;
    localparam logic [7:0] TRAILER_MARK = 8'hEF;
    localparam logic [7:0] CMD_DATA     = 8'h00;

    // width of the byte_index field on the output
    localparam int INDEX_W = 5;

    // kind of an incoming word, taken from tuser
    typedef enum logic {
        K_CLOSED = 1'b0,
        K_BYTE   = 1'b1
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_RECEIVING = 2'd0,
        ST_DATA      = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_CLOSED    = 2'd3
    } t_status;

    // classified word passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_item;

    // one result word
    typedef struct packed {
        t_status              status;
        logic [7:0]           data_byte;
        logic [INDEX_W-1:0]   byte_index;
        logic                 last;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/ffd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_present,
    input  wire logic [7:0]    i_byte,
    output logic               o_q_valid,
    output ffd_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);
    import ffd_pkg::*;

    // two-entry queue of classified words
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_item      item;
    logic       push;
    logic       pop;

    assign item.kind    = i_present ? K_BYTE : K_CLOSED;
    assign item.rx_byte = i_byte;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    assign push = i_valid && o_ready;
    assign pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ffd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffd_back #(
    parameter int FRAME_BYTES = 21,
    parameter int DATA_BYTES  = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire ffd_pkg::t_item i_q_item,
    output logic               o_q_pop,
    output logic               o_res_valid,
    output ffd_pkg::t_result   o_res,
    input  wire logic          i_res_ready
);
    import ffd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int FW = $clog2(FRAME_BYTES + 1);
    localparam int IW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int PW = $clog2(FRAME_BYTES + DATA_BYTES + 2);
    localparam int XW = (IW > INDEX_W) ? IW : INDEX_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HDR  = 7'b0000010,
        S_CMD  = 7'b0000100,
        S_DATA = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_COPY = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // frame buffer
    logic [7:0]    r_mem [FRAME_BYTES];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    t_state        r_state, n_state;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_shift, n_shift;
    logic [IW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_tr_ok, n_tr_ok;
    logic          r_ov;
    t_result       r_out;

    logic          can_emit;
    logic          emit;
    t_result       res;
    logic [PW-1:0] cur_pos;
    logic [PW-1:0] nxt_pos;
    logic          cur_in_range;
    logic          nxt_in_range;
    logic [XW-1:0] idx_x;
    logic          idx_last;

    assign can_emit = !r_ov || i_res_ready;

    // payload position of the current and next data byte
    assign cur_pos      = PW'(r_idx) + PW'(2);
    assign nxt_pos      = PW'(n_idx) + PW'(2);
    assign cur_in_range = (cur_pos < PW'(FRAME_BYTES));
    assign nxt_in_range = (nxt_pos < PW'(FRAME_BYTES));
    assign idx_x        = XW'(r_idx);
    assign idx_last     = (r_idx == IW'(DATA_BYTES - 1));

    // read data follows the next pointer, or the next data position in S_DATA, so r_rdata matches r_ptr / r_idx
    always_comb begin
        if (n_state == S_DATA) begin
            mem_raddr = nxt_in_range ? nxt_pos[AW-1:0] : '0;
        end else begin
            mem_raddr = n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_shift   = r_shift;
        n_idx     = r_idx;
        n_fill    = r_fill;
        n_tr_ok   = r_tr_ok;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        o_q_pop   = 1'b0;
        emit      = 1'b0;
        res       = '{status: ST_RECEIVING, data_byte: 8'd0,
                      byte_index: '0, last: 1'b1};

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && can_emit) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.kind == K_CLOSED) begin
                        emit       = 1'b1;
                        res.status = ST_CLOSED;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_fill[AW-1:0];
                        mem_wdata = i_q_item.rx_byte;
                        if (r_fill != FW'(FRAME_BYTES - 1)) begin
                            n_fill = r_fill + FW'(1);
                            emit   = 1'b1;
                        end else begin
                            // buffer full: check header and trailer
                            n_tr_ok = (i_q_item.rx_byte == TRAILER_MARK);
                            n_ptr   = '0;
                            n_state = S_HDR;
                        end
                    end
                end
            end
            S_HDR: begin
                n_ptr = AW'(1);
                if (r_rdata == HEADER_MARK && r_tr_ok) begin
                    n_state = S_CMD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_CMD: begin
                n_fill = '0;
                if (r_rdata == CMD_DATA) begin
                    n_idx   = '0;
                    n_state = S_DATA;
                end else if (can_emit) begin
                    emit       = 1'b1;
                    res.status = ST_IGNORED;
                    n_state    = S_IDLE;
                end
            end
            S_DATA: begin
                if (can_emit) begin
                    emit           = 1'b1;
                    res.status     = ST_DATA;
                    res.data_byte  = cur_in_range ? r_rdata : 8'd0;
                    res.byte_index = idx_x[INDEX_W-1:0];
                    res.last       = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_SCAN: begin
                if (r_rdata == HEADER_MARK) begin
                    n_shift = r_ptr;
                    n_state = S_COPY;
                end else if (r_ptr == AW'(FRAME_BYTES - 1)) begin
                    // no later header: drop everything
                    n_fill  = '0;
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_COPY: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr - r_shift;
                mem_wdata = r_rdata;
                if (r_ptr == AW'(FRAME_BYTES - 1)) begin
                    n_fill  = FW'(FRAME_BYTES) - FW'(r_shift);
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_DONE: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_shift <= n_shift;
        r_idx   <= n_idx;
        r_tr_ok <= n_tr_ok;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

`ifndef ASSERT_OFF
    a_fill_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FW'(FRAME_BYTES))
        else $error("fill count reached frame length");

    a_copy_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_shift != '0) && (r_ptr >= r_shift))
        else $error("slide with bad shift");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status != ST_DATA) |-> r_out.last)
        else $error("single status word without last");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> can_emit)
        else $error("result overwritten while waiting");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fixed_frame_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  tdata                              tuser              tlast
// s_axis    in   [7:0] rx_byte                      [0] byte_present   -
// m_axis    out  [7:0] data_byte, [12:8] byte_index [1:0] status       last
//
// a received byte is stored and answered with a receiving status word while the frame buffer fills
// a full buffer is checked for header and trailer, then for the command, and gives
// DATA_BYTES data words, or an ignored status word for another command, or a slide:
// header scan plus copy, then one status word
// reset is synchronous active low and empties the buffer at once
// a two-word input queue takes up to two words on s_axis while results wait on m_axis

module fixed_frame_deframer #(
    parameter int FRAME_BYTES = 21,
    parameter int DATA_BYTES  = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  wire logic [7:0]    i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic          i_s_axis_tuser,   // [0] byte_present
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata,   // [7:0] data_byte, [12:8] byte_index
    output logic [1:0]         o_m_axis_tuser,   // [1:0] status
    output logic               o_m_axis_tlast    // last word caused by one input word
);
    import ffd_pkg::*;

    // classified words waiting for the back end
    logic    q_valid;
    t_item   q_item;
    logic    q_pop;

    // registered result word
    logic    res_valid;
    t_result res;

    // front: takes words and marks them as byte or link closed
    ffd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_present (i_s_axis_tuser),
        .i_byte    (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // back: frame buffer, header scan, slide and data emission
    ffd_back #(
        .FRAME_BYTES (FRAME_BYTES),
        .DATA_BYTES  (DATA_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    // pack the result word onto the stream
    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tdata  = {3'b000, res.byte_index, res.data_byte};
    assign o_m_axis_tuser  = res.status;
    assign o_m_axis_tlast  = res.last;

endmodule

`default_nettype wire
